>>> sv/mwt_pkg.sv
// Shared constants, register codes, configuration struct and sequencer states
// for the median window threshold core. No dependencies.
`default_nettype none

package mwt_pkg;

	localparam int MAX_WIDTH   = 1024;
	localparam int WIN_R       = 2;
	localparam int WIN_SIDE    = 2 * WIN_R + 1;
	localparam int STORE_DEPTH = 2 * WIN_R * (MAX_WIDTH + 1) + 8;
	localparam int ADDR_W      = $clog2(STORE_DEPTH);
	localparam int OFF_W       = ADDR_W + 2;
	localparam int COL_W       = $clog2(MAX_WIDTH);
	localparam int WID_W       = 11;
	localparam int ROW_W       = 16;
	localparam int PIX_W       = 8;
	localparam int SIDE_W      = $clog2(WIN_SIDE);
	localparam int CNT_W       = $clog2(WIN_SIDE * WIN_SIDE + 1);
	localparam int PEND_W      = $clog2(WIN_R * MAX_WIDTH + WIN_R + 2);
	localparam int REG_IDX_W   = 3;
	localparam int REG_DATA_W  = 16;
	localparam int RST_WIDTH   = 1024;
	localparam int RST_HEIGHT  = 1;

	typedef enum logic [REG_IDX_W-1:0] {
		REG_IMAGE_WIDTH   = 3'd0,
		REG_IMAGE_HEIGHT  = 3'd1,
		REG_REGION_TOP    = 3'd2,
		REG_REGION_BOTTOM = 3'd3,
		REG_REGION_LEFT   = 3'd4,
		REG_REGION_RIGHT  = 3'd5
	} reg_idx_t;

	// effective geometry: width and height already clamped
	typedef struct packed {
		logic [WID_W-1:0] width;
		logic [ROW_W-1:0] height;
		logic [ROW_W-1:0] top;
		logic [ROW_W-1:0] bottom;
		logic [WID_W-1:0] left;
		logic [WID_W-1:0] right;
	} cfg_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CENTER,
		ST_SCAN,
		ST_TAIL,
		ST_DONE
	} state_t;

endpackage

`default_nettype wire

>>> sv/mwt_if.sv
// Handshake interfaces of the median window threshold core: pixel input,
// result output and register write channel. Depends on mwt_pkg.
`default_nettype none

interface mwt_in_if;
	import mwt_pkg::*;
	logic             valid;
	logic             ready;
	logic             kind;
	logic [PIX_W-1:0] pixel_value;
	modport source (output valid, output kind, output pixel_value, input ready);
	modport sink (input valid, input kind, input pixel_value, output ready);
endinterface

interface mwt_out_if;
	import mwt_pkg::*;
	logic             valid;
	logic             ready;
	logic [PIX_W-1:0] result_value;
	logic             last_of_frame;
	modport source (output valid, output result_value, output last_of_frame, input ready);
	modport sink (input valid, input result_value, input last_of_frame, output ready);
endinterface

interface mwt_cfg_if;
	import mwt_pkg::*;
	logic                  valid;
	logic                  ready;
	logic [REG_IDX_W-1:0]  addr;
	logic [REG_DATA_W-1:0] data;
	modport source (output valid, output addr, output data, input ready);
	modport sink (input valid, input addr, input data, output ready);
endinterface

`default_nettype wire

>>> sv/mwt_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module mwt_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 1024
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

`default_nettype wire

>>> sv/mwt_regs.sv
// Configuration registers with clamped geometry and a counter clear on write.
// Depends on mwt_pkg and mwt_if.
`default_nettype none

module mwt_regs (
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire logic  idle,
	mwt_cfg_if.sink    cfg,
	output mwt_pkg::cfg_t eff,
	output logic       clear
);
	import mwt_pkg::*;

	logic [WID_W-1:0] width_q;
	logic [ROW_W-1:0] height_q;
	logic [ROW_W-1:0] top_q;
	logic [ROW_W-1:0] bottom_q;
	logic [WID_W-1:0] left_q;
	logic [WID_W-1:0] right_q;
	logic             wr;
	logic             known;

	assign cfg.ready = idle;
	assign wr        = cfg.valid & cfg.ready;

	always_comb begin
		case (cfg.addr)
			REG_IMAGE_WIDTH, REG_IMAGE_HEIGHT, REG_REGION_TOP,
			REG_REGION_BOTTOM, REG_REGION_LEFT, REG_REGION_RIGHT: known = 1'b1;
			default: known = 1'b0;
		endcase
	end

	// any write to a known register abandons the frame in progress
	assign clear = wr & known;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= WID_W'(RST_WIDTH);
			height_q <= ROW_W'(RST_HEIGHT);
			top_q    <= '0;
			bottom_q <= '0;
			left_q   <= '0;
			right_q  <= '0;
		end else if (wr) begin
			case (cfg.addr)
				REG_IMAGE_WIDTH:   width_q  <= cfg.data[WID_W-1:0];
				REG_IMAGE_HEIGHT:  height_q <= cfg.data[ROW_W-1:0];
				REG_REGION_TOP:    top_q    <= cfg.data[ROW_W-1:0];
				REG_REGION_BOTTOM: bottom_q <= cfg.data[ROW_W-1:0];
				REG_REGION_LEFT:   left_q   <= cfg.data[WID_W-1:0];
				REG_REGION_RIGHT:  right_q  <= cfg.data[WID_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		eff = '0;
		if (width_q == '0) begin
			eff.width = WID_W'(1);
		end else if (width_q > WID_W'(MAX_WIDTH)) begin
			eff.width = WID_W'(MAX_WIDTH);
		end else begin
			eff.width = width_q;
		end
		eff.height = (height_q == '0) ? ROW_W'(1) : height_q;
		eff.top    = top_q;
		eff.bottom = bottom_q;
		eff.left   = left_q;
		eff.right  = right_q;
	end

endmodule

`default_nettype wire

>>> sv/median_window_threshold_core.sv
// Median window threshold core: inside the configured region, a pixel whose value is
// below the upper median of its clipped 5x5 window becomes zero; others pass unchanged.
// Results trail input by two rows plus two pixels. A beat that yields no result leaves
// the core idle for the next beat; a beat that yields a result holds the input through
// centre read, 25 window reads on the line memory's single read port, drain and decide.
// Reset clears counters and control registers, not the line memory or data registers.
`default_nettype none

module median_window_threshold_core (
	input  wire logic  clk,
	input  wire logic  arst_n,
	mwt_in_if.sink     pix_in,
	mwt_out_if.source  res_out,
	mwt_cfg_if.sink    cfg
);
	import mwt_pkg::*;

	// configuration
	cfg_t eff;
	logic clear;
	logic idle;

	// sequencer
	state_t state_q, state_d;

	// stream position
	logic [ROW_W-1:0]  in_row_q, out_row_q;
	logic [COL_W-1:0]  in_col_q, out_col_q;
	logic [ADDR_W-1:0] wr_ptr_q, out_ptr_q;
	logic [PEND_W-1:0] pend_q;

	// window scan
	logic [SIDE_W-1:0] dy_q, dx_q;
	logic              in_reg_q;
	logic              ctr_s1;
	logic              slot_ok_s1;
	logic [PIX_W-1:0]  center_q;
	logic [CNT_W-1:0]  cnt_q, nab_q;

	// output register
	logic             out_valid_q;
	logic [PIX_W-1:0] res_val_q;
	logic             res_last_q;

	// combinational
	logic              accept, in_done, is_pix, ram_we, emit_cond, start_scan;
	logic              in_region, row_ok, col_ok, slot_ok, last_slot, load;
	logic              in_wrap, oc_wrap, frame_end;
	logic [ROW_W:0]    yy;
	logic [WID_W:0]    xx;
	logic [PEND_W:0]   pend_inc, thr;
	logic signed [OFF_W-1:0] dys, dxs, wsg, row_off, sum;
	logic [ADDR_W-1:0] slot_addr, rd_addr;
	logic [PIX_W-1:0]  rdata;
	logic [PIX_W-1:0]  res_val;

	mwt_regs u_regs (
		.clk    (clk),
		.arst_n (arst_n),
		.idle   (idle),
		.cfg    (cfg),
		.eff    (eff),
		.clear  (clear)
	);

	// ring of recent pixels, addressed by raster index modulo its depth
	mwt_ram #(
		.WIDTH (PIX_W),
		.DEPTH (STORE_DEPTH)
	) u_line (
		.clk   (clk),
		.we    (ram_we),
		.waddr (wr_ptr_q),
		.wdata (pix_in.pixel_value),
		.raddr (rd_addr),
		.rdata (rdata)
	);

	// ---------------------------------------------------------------- input side
	assign accept  = pix_in.valid & pix_in.ready;
	assign in_done = in_row_q >= eff.height;
	assign is_pix  = ~pix_in.kind & ~in_done;
	assign ram_we  = accept & is_pix;

	// a result is due once more than R rows plus R pixels are waiting
	assign pend_inc  = (PEND_W+1)'(pend_q) + (PEND_W+1)'(1);
	assign thr       = (PEND_W+1)'(eff.width) * (PEND_W+1)'(WIN_R) + (PEND_W+1)'(WIN_R);
	assign emit_cond = pend_inc > thr;

	// drain beats (or pixels past frame end) only produce once input is complete
	assign start_scan = accept & (is_pix ? emit_cond : in_done);
	assign in_wrap    = (WID_W'(in_col_q) + WID_W'(1)) >= eff.width;

	// ---------------------------------------------------------------- window
	assign in_region = (out_row_q >= eff.top) && (out_row_q < eff.bottom) &&
	                   (WID_W'(out_col_q) >= eff.left) && (WID_W'(out_col_q) < eff.right);

	// offsets carry a +R bias so that the compares stay unsigned
	assign yy     = (ROW_W+1)'(out_row_q) + (ROW_W+1)'(dy_q);
	assign row_ok = (yy >= (ROW_W+1)'(eff.top) + (ROW_W+1)'(WIN_R)) &&
	                (yy <  (ROW_W+1)'(eff.bottom) + (ROW_W+1)'(WIN_R)) &&
	                (yy <  (ROW_W+1)'(eff.height) + (ROW_W+1)'(WIN_R));
	assign xx     = (WID_W+1)'(out_col_q) + (WID_W+1)'(dx_q);
	assign col_ok = (xx >= (WID_W+1)'(eff.left) + (WID_W+1)'(WIN_R)) &&
	                (xx <  (WID_W+1)'(eff.right) + (WID_W+1)'(WIN_R)) &&
	                (xx <  (WID_W+1)'(eff.width) + (WID_W+1)'(WIN_R));
	assign slot_ok   = in_reg_q & row_ok & col_ok;
	assign last_slot = (dy_q == SIDE_W'(WIN_SIDE - 1)) && (dx_q == SIDE_W'(WIN_SIDE - 1));

	// slot address: centre pointer + dy*width + dx, folded back into the ring
	assign dys     = OFF_W'(dy_q) - OFF_W'(WIN_R);
	assign dxs     = OFF_W'(dx_q) - OFF_W'(WIN_R);
	assign wsg     = OFF_W'(eff.width);
	assign row_off = dys * wsg;
	assign sum     = OFF_W'(out_ptr_q) + row_off + dxs;

	always_comb begin
		if (sum[OFF_W-1]) begin
			slot_addr = ADDR_W'(sum + OFF_W'(STORE_DEPTH));
		end else if (sum >= OFF_W'(STORE_DEPTH)) begin
			slot_addr = ADDR_W'(sum - OFF_W'(STORE_DEPTH));
		end else begin
			slot_addr = ADDR_W'(sum);
		end
	end

	// a pixel in the region is zeroed when at most count/2 window values are <= it
	assign res_val = (in_reg_q && (cnt_q != '0) && (nab_q <= (cnt_q >> 1))) ? '0 : center_q;

	// ---------------------------------------------------------------- output side
	assign oc_wrap   = (WID_W'(out_col_q) + WID_W'(1)) >= eff.width;
	assign frame_end = oc_wrap && ((ROW_W+1)'(out_row_q) + (ROW_W+1)'(1) >= (ROW_W+1)'(eff.height));

	// ---------------------------------------------------------------- sequencer
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE:   if (start_scan) state_d = ST_CENTER;
			ST_CENTER: state_d = ST_SCAN;
			ST_SCAN:   if (last_slot) state_d = ST_TAIL;
			ST_TAIL:   state_d = ST_DONE;
			ST_DONE:   if (!out_valid_q || res_out.ready) state_d = ST_IDLE;
			default:   state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		idle         = 1'b0;
		pix_in.ready = 1'b0;
		rd_addr      = slot_addr;
		load         = 1'b0;
		case (state_q)
			ST_IDLE: begin
				idle         = 1'b1;
				pix_in.ready = ~cfg.valid;
			end
			ST_CENTER: rd_addr = out_ptr_q;
			ST_DONE:   load = ~out_valid_q | res_out.ready;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// stream position counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_row_q  <= '0;
			in_col_q  <= '0;
			out_row_q <= '0;
			out_col_q <= '0;
			wr_ptr_q  <= '0;
			out_ptr_q <= '0;
			pend_q    <= '0;
		end else if (clear || (load && frame_end)) begin
			in_row_q  <= '0;
			in_col_q  <= '0;
			out_row_q <= '0;
			out_col_q <= '0;
			wr_ptr_q  <= '0;
			out_ptr_q <= '0;
			pend_q    <= '0;
		end else if (ram_we) begin
			in_col_q <= in_wrap ? '0 : in_col_q + COL_W'(1);
			in_row_q <= in_row_q + ROW_W'(in_wrap);
			wr_ptr_q <= (wr_ptr_q == ADDR_W'(STORE_DEPTH - 1)) ? '0 : wr_ptr_q + ADDR_W'(1);
			pend_q   <= pend_inc[PEND_W-1:0];
		end else if (load) begin
			out_col_q <= oc_wrap ? '0 : out_col_q + COL_W'(1);
			out_row_q <= out_row_q + ROW_W'(oc_wrap);
			out_ptr_q <= (out_ptr_q == ADDR_W'(STORE_DEPTH - 1)) ? '0 : out_ptr_q + ADDR_W'(1);
			pend_q    <= pend_q - PEND_W'(1);
		end
	end

	// window walk: read issued one slot per cycle, counted in the cycle after
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dy_q       <= '0;
			dx_q       <= '0;
			in_reg_q   <= 1'b0;
			ctr_s1     <= 1'b0;
			slot_ok_s1 <= 1'b0;
			cnt_q      <= '0;
			nab_q      <= '0;
		end else begin
			ctr_s1     <= (state_q == ST_CENTER);
			slot_ok_s1 <= (state_q == ST_SCAN) & slot_ok;
			if (state_q == ST_CENTER) begin
				dy_q     <= '0;
				dx_q     <= '0;
				in_reg_q <= in_region;
				cnt_q    <= '0;
				nab_q    <= '0;
			end else begin
				if (state_q == ST_SCAN) begin
					if (dx_q == SIDE_W'(WIN_SIDE - 1)) begin
						dx_q <= '0;
						dy_q <= dy_q + SIDE_W'(1);
					end else begin
						dx_q <= dx_q + SIDE_W'(1);
					end
				end
				if (slot_ok_s1) begin
					cnt_q <= cnt_q + CNT_W'(1);
					if (rdata <= center_q) begin
						nab_q <= nab_q + CNT_W'(1);
					end
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctr_s1) begin
			center_q <= rdata;
		end
	end

	// result register: lets the next beat in while a result waits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load) begin
			out_valid_q <= 1'b1;
		end else if (res_out.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			res_val_q  <= res_val;
			res_last_q <= frame_end;
		end
	end

	assign res_out.valid         = out_valid_q;
	assign res_out.result_value  = res_val_q;
	assign res_out.last_of_frame = res_last_q;

`ifndef ASSERT_OFF
	// waiting pixels never exceed the output delay plus the beat in hand
	a_pend_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(PEND_W+1)'(pend_q) <= thr + (PEND_W+1)'(1))
		else $error("pending count beyond window delay");

	// output row stays inside the frame
	a_out_row: assert property (@(posedge clk) disable iff (!arst_n)
		out_row_q < eff.height)
		else $error("output row outside frame");

	// a new result only appears from the decide step
	a_load_src: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q) == ST_DONE)
		else $error("result raised outside decide step");

	// a finished window waits while the result register is blocked
	a_done_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DONE && out_valid_q && !res_out.ready) |=> state_q == ST_DONE)
		else $error("result overwritten while stalled");
`endif

endmodule

`default_nettype wire
